FILE: hdl/hilbert_curve_vertex_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Hilbert curve vertex generator assertion macros
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HILBERT_CURVE_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define HILBERT_CURVE_VERTEX_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define HCVG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcvg assertion failed");

// next-cycle implication
`define HCVG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcvg assertion failed");

`endif

FILE: hdl/hcvg_pkg.sv
// ----------------------------------------------------------------------------
// hcvg_pkg
// Shared widths, codes and types of the Hilbert curve vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcvg_pkg;

    localparam int MAX_ORDER_DEF = 8;

    localparam int ORDER_W    = 4;
    localparam int STEP_W     = 6;
    localparam int START_W    = 10;
    localparam int COORD_W    = 15;
    localparam int HEAD_W     = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd3;

    localparam logic [HEAD_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [HEAD_W-1:0] DIR_UP    = 3'd1;
    localparam logic [HEAD_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [HEAD_W-1:0] DIR_DOWN  = 3'd3;
    localparam logic [HEAD_W-1:0] DIR_LEFT  = 3'd4;

    localparam logic [ORDER_W-1:0] RST_ORDER   = 4'd1;
    localparam logic [STEP_W-1:0]  RST_STEP    = 6'd10;
    localparam logic [START_W-1:0] RST_START_X = 10'd50;
    localparam logic [START_W-1:0] RST_START_Y = 10'd150;

    typedef struct packed {
        logic [ORDER_W-1:0] curve_order;
        logic [STEP_W-1:0]  step_length;
        logic [START_W-1:0] start_x;
        logic [START_W-1:0] start_y;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [HEAD_W-1:0]  heading;
        logic               final_vertex;
    } vertex_t;

    typedef struct packed {
        logic    has_result;
        vertex_t vtx;
    } step_t;

endpackage

FILE: hdl/hcvg_dir_decode.sv
// ----------------------------------------------------------------------------
// hcvg_dir_decode
// Heading of the next move, decoded from the base-4 digits of the move number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcvg_dir_decode #(
    parameter int MAX_ORDER = hcvg_pkg::MAX_ORDER_DEF
) (
    input  logic [2*MAX_ORDER-1:0]         move_index,
    input  logic [hcvg_pkg::ORDER_W-1:0]   order_eff,
    output logic [hcvg_pkg::HEAD_W-1:0]    heading
);
    import hcvg_pkg::*;

    localparam int IDX_W = 2 * MAX_ORDER;

    logic [IDX_W-1:0] move_num;
    logic             seen;
    logic [1:0]       low_dig;
    logic [1:0]       slot_flip;
    logic [1:0]       dig;
    logic [1:0]       slot;

    assign move_num = move_index + IDX_W'(1);

    // digit 0 flips slot by 1, digit 3 by 3; flips commute
    always_comb
    begin
        seen      = 1'b0;
        low_dig   = 2'd0;
        slot_flip = 2'd0;
        dig       = 2'd0;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            if (ORDER_W'(i) < order_eff)
            begin
                dig = move_num[2*i +: 2];
                if (seen)
                begin
                    case (dig)
                        2'd0:    slot_flip = slot_flip ^ 2'd1;
                        2'd3:    slot_flip = slot_flip ^ 2'd3;
                        default: slot_flip = slot_flip;
                    endcase
                end
                else if (dig != 2'd0)
                begin
                    seen    = 1'b1;
                    low_dig = dig;
                end
            end
        end
    end

    assign slot = (low_dig - 2'd1) ^ slot_flip;

    always_comb
    begin
        if (!seen)
        begin
            heading = DIR_NONE;
        end
        else
        begin
            case (slot)
                2'd0:    heading = DIR_DOWN;
                2'd1:    heading = DIR_RIGHT;
                2'd2:    heading = DIR_UP;
                default: heading = DIR_LEFT;
            endcase
        end
    end

endmodule

FILE: hdl/hcvg_vertex_state.sv
// ----------------------------------------------------------------------------
// hcvg_vertex_state
// Cursor, move counter and end flag; forms the vertex for the item in hand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcvg_vertex_state #(
    parameter int MAX_ORDER = hcvg_pkg::MAX_ORDER_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic            restart,
    input  hcvg_pkg::cfg_t  cfg,
    output hcvg_pkg::step_t res
);
    import hcvg_pkg::*;

    localparam int IDX_W = 2 * MAX_ORDER;

    logic [IDX_W-1:0]   move_index_reg, move_index_next;
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic               finished_reg, finished_next;

    logic [ORDER_W-1:0] order_eff;
    logic [ORDER_W:0]   twice_order;
    logic [IDX_W-1:0]   total;
    logic [IDX_W-1:0]   move_num;
    logic [HEAD_W-1:0]  dir;
    logic [COORD_W-1:0] step_ext;
    logic               can_move;

    assign order_eff   = (cfg.curve_order > ORDER_W'(MAX_ORDER)) ?
                         ORDER_W'(MAX_ORDER) : cfg.curve_order;
    assign twice_order = {order_eff, 1'b0};

    always_comb
    begin
        for (int j = 0; j < IDX_W; j++)
        begin
            total[j] = ((ORDER_W+1)'(j) < twice_order);
        end
    end

    assign move_num = move_index_reg + IDX_W'(1);
    assign step_ext = COORD_W'(cfg.step_length);
    assign can_move = !finished_reg && (move_index_reg < total);

    hcvg_dir_decode #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dir_decode (
        .move_index (move_index_reg),
        .order_eff  (order_eff),
        .heading    (dir)
    );

    always_comb
    begin
        move_index_next = move_index_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        finished_next   = finished_reg;
        res.has_result  = 1'b0;
        res.vtx.heading = DIR_NONE;
        if (restart)
        begin
            move_index_next = '0;
            cursor_x_next   = COORD_W'(cfg.start_x);
            cursor_y_next   = COORD_W'(cfg.start_y);
            finished_next   = (order_eff == '0);
            res.has_result  = 1'b1;
        end
        else if (can_move)
        begin
            case (dir)
                DIR_UP:    cursor_y_next = cursor_y_reg - step_ext;
                DIR_RIGHT: cursor_x_next = cursor_x_reg + step_ext;
                DIR_DOWN:  cursor_y_next = cursor_y_reg + step_ext;
                DIR_LEFT:  cursor_x_next = cursor_x_reg - step_ext;
                default:   cursor_x_next = cursor_x_reg;
            endcase
            move_index_next = move_num;
            if (move_num == total)
            begin
                finished_next = 1'b1;
            end
            res.has_result  = 1'b1;
            res.vtx.heading = dir;
        end
        res.vtx.pos_x        = cursor_x_next;
        res.vtx.pos_y        = cursor_y_next;
        res.vtx.final_vertex = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_index_reg <= '0;
            cursor_x_reg   <= COORD_W'(RST_START_X);
            cursor_y_reg   <= COORD_W'(RST_START_Y);
            finished_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            move_index_reg <= move_index_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            finished_reg   <= finished_next;
        end
    end

endmodule

FILE: hdl/hilbert_curve_vertex_generator_unit.sv
// Path: an input transfer is held in the input reg, then its result in the result reg.
// Throughput: one item per cycle unless out_ready stalls the output; the cursor/counter update is combinational.
// Advance items past the curve end are consumed and give no result.
// Reset: config to order 1, step 10, start (50,150); cursor (50,150), count 0.
// ----------------------------------------------------------------------------
// hilbert_curve_vertex_generator_unit
// Emits Hilbert curve vertices, one per advance transfer up to the curve end, restart to start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hilbert_curve_vertex_generator_unit #(
    parameter int MAX_ORDER = hcvg_pkg::MAX_ORDER_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hcvg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcvg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hcvg_pkg::COORD_W-1:0]    pos_x,
    output logic [hcvg_pkg::COORD_W-1:0]    pos_y,
    output logic [hcvg_pkg::HEAD_W-1:0]     heading,
    output logic                            final_vertex
);
    import hcvg_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_restart_reg;
    logic    out_valid_reg, out_valid_next;
    vertex_t out_vtx_reg;
    step_t   step_res;
    logic    s1_fire;
    logic    in_xfer;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORDER:   cfg_next.curve_order = cfg_data[ORDER_W-1:0];
                CFG_STEP:    cfg_next.step_length = cfg_data[STEP_W-1:0];
                CFG_START_X: cfg_next.start_x     = cfg_data[START_W-1:0];
                CFG_START_Y: cfg_next.start_y     = cfg_data[START_W-1:0];
                default:     cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curve_order <= RST_ORDER;
            cfg_reg.step_length <= RST_STEP;
            cfg_reg.start_x     <= RST_START_X;
            cfg_reg.start_y     <= RST_START_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_xfer  = in_valid && in_ready;

    hcvg_vertex_state #(
        .MAX_ORDER (MAX_ORDER)
    ) u_vertex_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_fire),
        .restart (s1_restart_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = step_res.has_result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_restart_reg <= restart;
        end
        if (s1_fire && step_res.has_result)
        begin
            out_vtx_reg <= step_res.vtx;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = out_vtx_reg.pos_x;
    assign pos_y        = out_vtx_reg.pos_y;
    assign heading      = out_vtx_reg.heading;
    assign final_vertex = out_vtx_reg.final_vertex;

`include "hilbert_curve_vertex_generator_unit_assert.svh"

    `HCVG_ASSERT_NEXT(a_restart_start, s1_fire && s1_restart_reg, out_valid_reg && heading == DIR_NONE && pos_x == COORD_W'($past(cfg_reg.start_x)))
    `HCVG_ASSERT_NEXT(a_move_heading, s1_fire && !s1_restart_reg && step_res.has_result, out_valid_reg && heading != DIR_NONE)
    `HCVG_ASSERT_NEXT(a_no_result, s1_fire && !step_res.has_result, !out_valid_reg)
    `HCVG_ASSERT_NOW(a_restart_result, s1_valid_reg && s1_restart_reg, step_res.has_result)

endmodule
